FILE: hw/rtl/bzg_pkg.sv
// ============================================================================
// bzg_pkg
// Shared constants and types for the cubic Bezier point generator: parameter
// step format, resolution register format and sequencer status.
// ============================================================================
package bzg_pkg;

    // default coordinate width (signed Q8.8 at 16 bits)
    localparam int unsigned CW_DEFAULT = 16;

    // resolution register
    localparam int unsigned RES_W     = 6;
    localparam logic [RES_W-1:0] RES_RESET = 6'd16;

    // curve parameter t: unsigned Q1.16, t = 1.0 is exact
    localparam int unsigned FRAC_W = 16;
    localparam int unsigned T_W    = FRAC_W + 1;
    localparam int unsigned T_ONE  = 65536;

    // sequencer status toward the datapath control
    typedef struct packed {
        logic busy;   // segment in progress, points still to issue
        logic vld;    // issue stage holds a point
        logic last;   // issued point is the one at t = 1
    } t_seq_stat;

endpackage

FILE: hw/rtl/bzg_seq.sv
// ============================================================================
// bzg_seq
// Point sequencer: latches one segment's control points and steps t from 0
// to 1 in res equal steps, one point per enabled cycle. t = floor(i*2^16/n)
// is built incrementally from a quotient/remainder step table.
// ============================================================================
module bzg_seq #(
    parameter int unsigned COORD_WIDTH = bzg_pkg::CW_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_start,
    input  logic [bzg_pkg::RES_W-1:0]            i_res,
    input  logic signed [COORD_WIDTH-1:0]        i_x [4],
    input  logic signed [COORD_WIDTH-1:0]        i_y [4],
    output logic signed [COORD_WIDTH-1:0]        o_x [4],
    output logic signed [COORD_WIDTH-1:0]        o_y [4],
    output logic [bzg_pkg::T_W-1:0]              o_t,
    output bzg_pkg::t_seq_stat                   o_stat
);
    import bzg_pkg::*;

    localparam int unsigned TabN = 2**RES_W;

    logic [T_W-1:0]   w_tab_q [TabN];
    logic [RES_W-1:0] w_tab_r [TabN];

    logic [RES_W-1:0] w_n;
    logic [RES_W:0]   w_rem_sum;
    logic             w_wrap;
    logic [RES_W-1:0] n_rem;
    logic [T_W-1:0]   n_tacc;

    logic             r_busy;
    logic             r_v;
    logic             r_last;
    logic [RES_W-1:0] r_i;
    logic [RES_W-1:0] r_n;
    logic [T_W-1:0]   r_q;
    logic [RES_W-1:0] r_r;
    logic [T_W-1:0]   r_tacc;
    logic [RES_W-1:0] r_rem;
    logic [T_W-1:0]   r_t;
    logic signed [COORD_WIDTH-1:0] r_x [4];
    logic signed [COORD_WIDTH-1:0] r_y [4];

    // step table: 2^16 / n as quotient and remainder, worked out at elaboration
    for (genvar g = 0; g < TabN; g++) begin : g_tab
        localparam int unsigned Div = (g == 0) ? 1 : g;
        localparam int unsigned Q   = T_ONE / Div;
        localparam int unsigned R   = T_ONE % Div;
        assign w_tab_q[g] = T_W'(Q);
        assign w_tab_r[g] = RES_W'(R);
    end

    // a resolution of zero runs as one step
    assign w_n = (i_res == '0) ? RES_W'(1) : i_res;

    // next t: add quotient, carry one when the remainder wraps past n
    always_comb begin
        w_rem_sum = {1'b0, r_rem} + {1'b0, r_r};
        w_wrap    = (w_rem_sum >= {1'b0, r_n});
        n_rem     = w_wrap ? RES_W'(w_rem_sum - {1'b0, r_n}) : w_rem_sum[RES_W-1:0];
        n_tacc    = r_tacc + r_q + T_W'(w_wrap);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_v    <= 1'b0;
            r_last <= 1'b0;
            r_i    <= '0;
            r_n    <= RES_W'(1);
            r_q    <= '0;
            r_r    <= '0;
            r_tacc <= '0;
            r_rem  <= '0;
        end else begin
            if (i_en) begin
                if (r_busy) begin
                    r_v    <= 1'b1;
                    r_last <= (r_i == r_n);
                    r_i    <= r_i + RES_W'(1);
                    r_tacc <= n_tacc;
                    r_rem  <= n_rem;
                    if (r_i == r_n) begin
                        r_busy <= 1'b0;
                    end
                end else begin
                    r_v <= 1'b0;
                end
            end
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_n    <= w_n;
                r_q    <= w_tab_q[w_n];
                r_r    <= w_tab_r[w_n];
                r_tacc <= '0;
                r_rem  <= '0;
            end
        end
    end

    // payload: issued t and the held control points
    always_ff @(posedge i_clk) begin
        if (i_en && r_busy) begin
            r_t <= r_tacc;
        end
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_x         = r_x;
    assign o_y         = r_y;
    assign o_t         = r_t;
    assign o_stat.busy = r_busy;
    assign o_stat.vld  = r_v;
    assign o_stat.last = r_last;

endmodule

FILE: hw/rtl/bzg_cast.sv
// ============================================================================
// bzg_cast
// One coordinate of the curve: three registered de Casteljau levels with
// unnormalized weights s = 1-t, so the final level is the exact Bernstein
// sum scaled by 2^48. Each lerp is a*2^16 + t*(b-a), one multiplier.
// ============================================================================
module bzg_cast #(
    parameter int unsigned COORD_WIDTH = bzg_pkg::CW_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [bzg_pkg::T_W-1:0]       i_t,
    input  logic signed [COORD_WIDTH-1:0] i_p [4],
    output logic signed [COORD_WIDTH-1:0] o_q
);
    import bzg_pkg::*;

    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned L1W = W + FRAC_W;
    localparam int unsigned L2W = W + 2*FRAC_W;
    localparam int unsigned L3W = W + 3*FRAC_W;
    localparam int unsigned RSH = 3*FRAC_W;
    localparam logic signed [L3W-1:0] Half = L3W'(1) << (RSH - 1);

    logic signed [T_W:0]     w_ts0, w_ts1, w_ts2;
    logic signed [W:0]       w_d1 [3];
    logic signed [W+18:0]    w_s1 [3];
    logic signed [L1W:0]     w_d2 [2];
    logic signed [L1W+18:0]  w_s2 [2];
    logic signed [L2W:0]     w_d3;
    logic signed [L2W+18:0]  w_s3;
    logic signed [L3W-1:0]   w_rnd;

    logic [T_W-1:0]          r_t1, r_t2;
    logic signed [L1W-1:0]   r_a [3];
    logic signed [L2W-1:0]   r_b [2];
    logic signed [L3W-1:0]   r_c;

    assign w_ts0 = {1'b0, i_t};
    assign w_ts1 = {1'b0, r_t1};
    assign w_ts2 = {1'b0, r_t2};

    // level 1: control points to three lerps
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_d1[k] = {i_p[k+1][W-1], i_p[k+1]} - {i_p[k][W-1], i_p[k]};
            w_s1[k] = $signed({{3{i_p[k][W-1]}}, i_p[k], {FRAC_W{1'b0}}})
                    + w_d1[k] * w_ts0;
        end
    end

    // level 2
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_d2[k] = {r_a[k+1][L1W-1], r_a[k+1]} - {r_a[k][L1W-1], r_a[k]};
            w_s2[k] = $signed({{3{r_a[k][L1W-1]}}, r_a[k], {FRAC_W{1'b0}}})
                    + w_d2[k] * w_ts1;
        end
    end

    // level 3
    always_comb begin
        w_d3 = {r_b[1][L2W-1], r_b[1]} - {r_b[0][L2W-1], r_b[0]};
        w_s3 = $signed({{3{r_b[0][L2W-1]}}, r_b[0], {FRAC_W{1'b0}}}) + w_d3 * w_ts2;
    end

    // level registers; each level value stays in its narrowed range
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1 <= i_t;
            r_t2 <= r_t1;
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= w_s1[k][L1W-1:0];
            end
            for (int k = 0; k < 2; k++) begin
                r_b[k] <= w_s2[k][L2W-1:0];
            end
            r_c <= w_s3[L3W-1:0];
        end
    end

    // round half up and drop the 2^48 scale; a convex blend cannot overflow
    assign w_rnd = r_c + Half;
    assign o_q   = w_rnd[L3W-1:RSH];

endmodule

FILE: hw/rtl/cubic_bezier_point_generator_core.sv
// ============================================================================
// cubic_bezier_point_generator_core
// Cubic Bezier segment to res+1 curve points, rounded, with a last flag.
// ============================================================================
// One input transaction carries the four control points of a segment; the
// block then returns res+1 points (res from the resolution register, zero
// counts as one) at t = i/res, one point per cycle while the output side
// takes them. The point sequencer issues into a five-register pipeline
// (issue, three de Casteljau levels, output register). A new segment is
// taken only once the sequencer has issued the previous segment's last
// point. Output stalls freeze the whole pipeline. Write the resolution
// register only while the block is idle.
module cubic_bezier_point_generator_core #(
    parameter int unsigned COORD_WIDTH = bzg_pkg::CW_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // resolution register
    input  logic                           i_res_we,
    input  logic [bzg_pkg::RES_W-1:0]      i_res_wdata,
    // control point input
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [COORD_WIDTH-1:0]  i_x0,
    input  logic signed [COORD_WIDTH-1:0]  i_y0,
    input  logic signed [COORD_WIDTH-1:0]  i_x1,
    input  logic signed [COORD_WIDTH-1:0]  i_y1,
    input  logic signed [COORD_WIDTH-1:0]  i_x2,
    input  logic signed [COORD_WIDTH-1:0]  i_y2,
    input  logic signed [COORD_WIDTH-1:0]  i_x3,
    input  logic signed [COORD_WIDTH-1:0]  i_y3,
    // curve point output
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [COORD_WIDTH-1:0]  o_px,
    output logic signed [COORD_WIDTH-1:0]  o_py,
    output logic                           o_last
);
    import bzg_pkg::*;

    logic [RES_W-1:0]              r_res;
    logic                          w_en;
    logic                          w_start;
    t_seq_stat                     w_stat;
    logic [T_W-1:0]                w_t;
    logic signed [COORD_WIDTH-1:0] w_in_x [4];
    logic signed [COORD_WIDTH-1:0] w_in_y [4];
    logic signed [COORD_WIDTH-1:0] w_px [4];
    logic signed [COORD_WIDTH-1:0] w_py [4];
    logic signed [COORD_WIDTH-1:0] w_qx, w_qy;

    logic                          r_v1, r_v2, r_v3;
    logic                          r_l1, r_l2, r_l3;
    logic                          r_out_valid;
    logic                          r_last;
    logic signed [COORD_WIDTH-1:0] r_px, r_py;

    // resolution register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= RES_RESET;
        end else if (i_res_we) begin
            r_res <= i_res_wdata;
        end
    end

    // pipeline moves when the output register is free or being taken
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = !w_stat.busy && (!w_stat.vld || w_en);
    assign w_start    = i_in_valid && o_in_ready;

    assign w_in_x = '{i_x0, i_x1, i_x2, i_x3};
    assign w_in_y = '{i_y0, i_y1, i_y2, i_y3};

    bzg_seq #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_start (w_start),
        .i_res   (r_res),
        .i_x     (w_in_x),
        .i_y     (w_in_y),
        .o_x     (w_px),
        .o_y     (w_py),
        .o_t     (w_t),
        .o_stat  (w_stat)
    );

    bzg_cast #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cast_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (w_t),
        .i_p   (w_px),
        .o_q   (w_qx)
    );

    bzg_cast #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_cast_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_t   (w_t),
        .i_p   (w_py),
        .o_q   (w_qy)
    );

    // valid and last travel alongside the datapath levels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v1        <= w_stat.vld;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_out_valid <= r_v3;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_l1   <= w_stat.last;
            r_l2   <= r_l1;
            r_l3   <= r_l2;
            r_last <= r_l3;
            r_px   <= w_qx;
            r_py   <= w_qy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_px        = r_px;
    assign o_py        = r_py;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    // an accepted segment starts the sequencer
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> w_stat.busy)
        else $error("sequencer not busy after segment accept");

    // never accept a segment while points remain to issue
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_stat.busy)
        else $error("input ready during a running segment");

    // the point at t = 1 issues as the sequencer goes idle
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.vld && w_stat.last) |-> !w_stat.busy)
        else $error("sequencer busy after last point issued");

    // a stall freezes the internal valid chain
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable({r_v1, r_v2, r_v3}))
        else $error("pipeline valid bits moved during a stall");
`endif

endmodule

FILE: tb/cubic_bezier_point_generator_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// cubic_bezier_point_generator_core_tb
// Self-checking bench for the cubic Bezier point generator.
// ----------------------------------------------------------------------------
// Each segment sent is expanded by a local fixed-point evaluator into the
// res+1 curve points it must produce. Output transactions are compared in
// order against those points. Directed segments cover the coordinate
// extremes, resolution zero/one/max and the round-half-up boundary. Random
// segments then run under three handshake idle profiles and several
// resolution settings.
// ============================================================================
module cubic_bezier_point_generator_core_tb;

    import bzg_pkg::*;

    localparam int      CW       = CW_DEFAULT;
    localparam longint  COORD_MAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint  COORD_MIN = -(64'sd1 <<< (CW - 1));
    localparam int      CLK_HALF = 6;
    localparam int      SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [3:0][CW-1:0] x;
        logic [3:0][CW-1:0] y;
    } t_ctrl_seg;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic                 last;
    } t_curve_pt;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_res_we;
    logic [RES_W-1:0]       i_res_wdata;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic signed [CW-1:0]   i_x0, i_y0, i_x1, i_y1, i_x2, i_y2, i_x3, i_y3;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic signed [CW-1:0]   o_px, o_py;
    logic                   o_last;

    // predictor state and bookkeeping
    logic [RES_W-1:0]       cur_res;
    t_curve_pt              expected_points[$];
    int                     src_idle_pct;
    int                     sink_stall_pct;
    int                     error_count;
    int                     segments_sent;
    int                     points_checked;

    cubic_bezier_point_generator_core #(
        .COORD_WIDTH (CW)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_we    (i_res_we),
        .i_res_wdata (i_res_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x0        (i_x0),
        .i_y0        (i_y0),
        .i_x1        (i_x1),
        .i_y1        (i_y1),
        .i_x2        (i_x2),
        .i_y2        (i_y2),
        .i_x3        (i_x3),
        .i_y3        (i_y3),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_px        (o_px),
        .o_py        (o_py),
        .o_last      (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("%0t: timeout, curve points still outstanding: %0d",
                 $time, expected_points.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Fixed-point evaluator
    // ------------------------------------------------------------------------

    // exact weighted sum over 2^48, round half up, saturate
    function automatic logic signed [CW-1:0] blend_coord(
        input logic [3:0][63:0]   w,
        input logic [3:0][CW-1:0] c
    );
        logic signed [81:0] acc;
        logic signed [81:0] q;
        acc = 82'sd1 <<< 47;
        for (int k = 0; k < 4; k++)
            acc = acc + $signed({1'b0, w[k][49:0]}) * $signed(c[k]);
        q = acc >>> 48;
        if (q > COORD_MAX)
            q = COORD_MAX;
        else if (q < COORD_MIN)
            q = COORD_MIN;
        return q[CW-1:0];
    endfunction

    // expand one segment into its res+1 curve points
    function automatic void queue_curve_points(input t_ctrl_seg seg);
        logic [63:0]      n;
        logic [63:0]      t;
        logic [63:0]      s;
        logic [3:0][63:0] w;
        t_curve_pt        pt;
        n = (cur_res == '0) ? 64'd1 : 64'(cur_res);
        for (longint i = 0; i <= n; i++) begin
            t = (64'(i) * 64'(T_ONE)) / n;
            s = 64'(T_ONE) - t;
            w[0] = s * s * s;
            w[1] = 64'd3 * s * s * t;
            w[2] = 64'd3 * s * t * t;
            w[3] = t * t * t;
            pt.px   = blend_coord(w, seg.x);
            pt.py   = blend_coord(w, seg.y);
            pt.last = (64'(i) == n);
            expected_points.insert(expected_points.size(), pt);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall and in-order compare
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_curve_pt exp_pt;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_points.size() == 0) begin
                error_count++;
                $display("%0t: unexpected point px=%0d py=%0d last=%0b",
                         $time, o_px, o_py, o_last);
            end else begin
                exp_pt = expected_points.pop_front();
                points_checked++;
                if (o_px !== exp_pt.px) begin
                    error_count++;
                    $display("%0t: px mismatch expected %0d actual %0d",
                             $time, exp_pt.px, o_px);
                end
                if (o_py !== exp_pt.py) begin
                    error_count++;
                    $display("%0t: py mismatch expected %0d actual %0d",
                             $time, exp_pt.py, o_py);
                end
                if (o_last !== exp_pt.last) begin
                    error_count++;
                    $display("%0t: last mismatch expected %0b actual %0b",
                             $time, exp_pt.last, o_last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // one segment transaction; called right after a rising edge
    task automatic send_segment(input t_ctrl_seg seg);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_x0 <= seg.x[0];
        i_y0 <= seg.y[0];
        i_x1 <= seg.x[1];
        i_y1 <= seg.y[1];
        i_x2 <= seg.x[2];
        i_y2 <= seg.y[2];
        i_x3 <= seg.x[3];
        i_y3 <= seg.y[3];
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        queue_curve_points(seg);
        segments_sent++;
    endtask

    task automatic wait_points_drained();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // resolution change, only once the pipeline is empty
    task automatic set_resolution(input logic [RES_W-1:0] val);
        wait_points_drained();
        i_res_we    <= 1'b1;
        i_res_wdata <= val;
        @(posedge i_clk);
        i_res_we    <= 1'b0;
        cur_res = val;
    endtask

    function automatic t_ctrl_seg uniform_seg(input logic [CW-1:0] xv,
                                              input logic [CW-1:0] yv);
        t_ctrl_seg seg;
        for (int k = 0; k < 4; k++) begin
            seg.x[k] = xv;
            seg.y[k] = yv;
        end
        return seg;
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(3))
                    0: return COORD_MAX[CW-1:0];
                    1: return COORD_MIN[CW-1:0];
                    2: return '0;
                    default: return '1;
                endcase
            end
            1: return CW'($urandom_range(511)) - CW'(256);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic t_ctrl_seg rand_seg();
        t_ctrl_seg seg;
        for (int k = 0; k < 4; k++) begin
            seg.x[k] = rand_coord();
            seg.y[k] = rand_coord();
        end
        // occasionally collapse to a single point: output must be exact
        if ($urandom_range(9) == 0)
            seg = uniform_seg(seg.x[0], seg.y[0]);
        return seg;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset resolution with coordinate extremes
    task automatic test_default_resolution();
        t_ctrl_seg seg;
        send_segment(uniform_seg('0, '0));
        send_segment(uniform_seg(COORD_MAX[CW-1:0], COORD_MIN[CW-1:0]));
        send_segment(uniform_seg(COORD_MIN[CW-1:0], COORD_MAX[CW-1:0]));
        send_segment(uniform_seg('1, '1));
        // alternating extremes swing the curve across the full range
        for (int k = 0; k < 4; k++) begin
            seg.x[k] = k[0] ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
            seg.y[k] = k[0] ? COORD_MIN[CW-1:0] : COORD_MAX[CW-1:0];
        end
        send_segment(seg);
        send_segment(rand_seg());
    endtask

    // a zero resolution behaves as one: two points per segment
    task automatic test_resolution_zero();
        set_resolution('0);
        send_segment(uniform_seg(COORD_MIN[CW-1:0], COORD_MAX[CW-1:0]));
        send_segment(rand_seg());
    endtask

    // t = 1/2 with weights 1/8, 3/8, 3/8, 1/8: exact halves round up
    task automatic test_round_half_up();
        t_ctrl_seg seg;
        set_resolution(RES_W'(2));
        seg = uniform_seg('0, '0);
        seg.x[0] = CW'(4);
        seg.y[0] = -CW'(4);
        send_segment(seg);
        seg.x[3] = CW'(4);
        seg.y[3] = -CW'(4);
        seg.x[1] = CW'(1);
        seg.y[2] = -CW'(1);
        send_segment(seg);
        send_segment(rand_seg());
    endtask

    // smallest and largest step counts
    task automatic test_resolution_extremes();
        set_resolution(RES_W'(1));
        send_segment(rand_seg());
        send_segment(uniform_seg(COORD_MAX[CW-1:0], COORD_MAX[CW-1:0]));
        set_resolution('1);
        send_segment(rand_seg());
        send_segment(uniform_seg(COORD_MIN[CW-1:0], COORD_MIN[CW-1:0]));
        send_segment(rand_seg());
    endtask

    // random segments under one idle profile, a few resolutions each
    task automatic test_random_traffic(input int src_pct, input int sink_pct,
                                       input int n_items);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int chunk = 0; chunk < 3; chunk++) begin
            set_resolution(RES_W'($urandom_range(0, (1 << RES_W) - 1)));
            for (int i = 0; i < n_items / 3; i++)
                send_segment(rand_seg());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_res_we       = 1'b0;
        i_res_wdata    = '0;
        i_in_valid     = 1'b0;
        i_out_ready    = 1'b0;
        {i_x0, i_y0, i_x1, i_y1, i_x2, i_y2, i_x3, i_y3} = '0;
        cur_res        = RES_RESET;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        error_count    = 0;
        segments_sent  = 0;
        points_checked = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_resolution();
        test_resolution_zero();
        test_round_half_up();
        test_resolution_extremes();
        test_random_traffic(15, 82, 54);
        test_random_traffic(82, 15, 54);
        test_random_traffic(0, 0, 54);

        wait_points_drained();
        if (expected_points.size() != 0) begin
            error_count++;
            $display("%0t: %0d curve points never arrived",
                     $time, expected_points.size());
        end

        $display("Ran %0d segments and checked %0d curve points over", segments_sent,
                 points_checked);
        $display("resolutions 0, 1, 2, 16, 63 and random, with three idle profiles");
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
